// ===== sv/slwm_pkg.sv =====
// shared types and constants for the sql like wildcard matcher
`default_nettype none
package slwm_pkg;

    typedef enum logic [1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_APPEND  = 2'd1,
        CMD_SUBJECT = 2'd2,
        CMD_END     = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_LIT = 2'd0,
        KIND_ONE = 2'd1,
        KIND_RUN = 2'd2
    } t_kind;

    localparam logic [7:0] CH_RUN = 8'h25;
    localparam logic [7:0] CH_ONE = 8'h5F;
    localparam logic [7:0] CH_ESC = 8'h5C;

    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] char_byte;
    } t_in;

    typedef struct packed {
        logic matched;
        logic pattern_overflow;
    } t_out;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic       en;
        logic       step;
        logic       wr_en;
        t_kind      kind;
        logic [7:0] chr;
    } t_cell_ctl;

endpackage
`default_nettype wire

// ===== sv/slwm_cell.sv =====
// one pattern element and the active bit of its position
`default_nettype none
module slwm_cell #(
    parameter int IDX   = 0,
    parameter int LEN_W = 6
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire slwm_pkg::t_cell_ctl i_ctl,
    input  wire  [LEN_W-1:0]       i_len,
    input  wire  [LEN_W-1:0]       i_len_next,
    input  wire                    i_hop,
    input  wire                    i_carry,
    output logic                   o_hop,
    output logic                   o_carry,
    output logic                   o_active
);

    slwm_pkg::t_kind r_kind;
    logic [7:0]      r_char;
    logic            r_active;
    logic            n_active;

    logic            wr_here;
    slwm_pkg::t_kind eff_kind;
    logic [7:0]      eff_char;
    logic            valid;
    logic            is_run;
    logic            self_keep;
    logic            post;

    assign wr_here  = i_ctl.en && i_ctl.wr_en && (i_len == LEN_W'(IDX));
    assign eff_kind = wr_here ? i_ctl.kind : r_kind;
    assign eff_char = wr_here ? i_ctl.chr : r_char;
    assign valid    = i_len_next > LEN_W'(IDX);
    assign is_run   = valid && (eff_kind == slwm_pkg::KIND_RUN);

    // a run element keeps its position alive, others advance on a match
    assign self_keep = i_ctl.step && r_active && is_run;
    assign o_hop     = i_ctl.step && r_active && valid && !is_run &&
                       ((eff_kind == slwm_pkg::KIND_ONE) || (eff_char == i_ctl.chr));

    // closure ripples through consecutive run elements
    assign post     = self_keep || i_hop || i_carry;
    assign o_carry  = post && is_run;
    assign o_active = r_active;
    assign n_active = i_ctl.en ? post : r_active;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= (IDX == 0);
        end else begin
            r_active <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_here) begin
            r_kind <= i_ctl.kind;
            r_char <= i_ctl.chr;
        end
    end

endmodule
`default_nettype wire

// ===== sv/sql_like_wildcard_matcher_core.sv =====
// top level: pattern decode, chain of element cells, result register
//
//   channel | direction | handshake                  | payload
//   in      | input     | i_in_valid / o_in_stall    | i_in_data  (slwm_pkg::t_in)
//   out     | output    | o_out_valid / i_out_stall  | o_out_data (slwm_pkg::t_out)
//
// one input beat per cycle while o_in_stall is low; the active set of all
// PATTERN_MAX+1 positions (cells plus r_last) is updated in the cycle it is taken
// the closure over runs of '%' ripples through the cells within that cycle
// reset (synchronous, i_rst_n low) empties the pattern and arms position zero
// an end beat waits only while a result is held under i_out_stall; other beats pass
module sql_like_wildcard_matcher_core #(
    parameter int PATTERN_MAX = 32
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    input  wire slwm_pkg::t_in i_in_data,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output slwm_pkg::t_out     o_out_data,
    input  wire                i_out_stall
);

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);

    logic [LEN_W-1:0]     r_len;
    logic [LEN_W-1:0]     n_len;
    logic                 r_esc;
    logic                 n_esc;
    logic                 r_ovf;
    logic                 n_ovf;
    logic                 r_last;
    logic                 n_last;
    logic                 r_out_valid;
    slwm_pkg::t_out       r_out;

    logic                 in_acc;
    logic                 is_clear;
    logic                 is_append;
    logic                 is_step;
    logic                 is_end;
    logic                 append_elem;
    logic                 full;
    slwm_pkg::t_kind      new_kind;
    slwm_pkg::t_cell_ctl  ctl;
    logic [PATTERN_MAX:0] hop;
    logic [PATTERN_MAX:0] carry;
    logic [PATTERN_MAX:0] w_act;

    assign o_in_stall = r_out_valid && i_out_stall && (i_in_data.cmd == slwm_pkg::CMD_END);
    assign in_acc     = i_in_valid && !o_in_stall;

    assign is_clear  = i_in_data.cmd == slwm_pkg::CMD_CLEAR;
    assign is_append = i_in_data.cmd == slwm_pkg::CMD_APPEND;
    assign is_step   = i_in_data.cmd == slwm_pkg::CMD_SUBJECT;
    assign is_end    = i_in_data.cmd == slwm_pkg::CMD_END;

    // an unescaped backslash only arms the escape
    assign append_elem = is_append && (r_esc || (i_in_data.char_byte != slwm_pkg::CH_ESC));
    assign full        = r_len == LEN_W'(PATTERN_MAX);

    always_comb begin
        new_kind = slwm_pkg::KIND_LIT;
        if (!r_esc) begin
            case (i_in_data.char_byte)
                slwm_pkg::CH_RUN: new_kind = slwm_pkg::KIND_RUN;
                slwm_pkg::CH_ONE: new_kind = slwm_pkg::KIND_ONE;
                default:          new_kind = slwm_pkg::KIND_LIT;
            endcase
        end
    end

    always_comb begin
        n_len = r_len;
        n_esc = r_esc;
        n_ovf = r_ovf;
        if (in_acc) begin
            case (i_in_data.cmd)
                slwm_pkg::CMD_CLEAR: begin
                    n_len = '0;
                    n_esc = 1'b0;
                    n_ovf = 1'b0;
                end
                slwm_pkg::CMD_APPEND: begin
                    n_esc = !r_esc && (i_in_data.char_byte == slwm_pkg::CH_ESC);
                    if (append_elem) begin
                        if (full) begin
                            n_ovf = 1'b1;
                        end else begin
                            n_len = r_len + LEN_W'(1);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign ctl.en    = in_acc;
    assign ctl.step  = is_step;
    assign ctl.wr_en = append_elem && !full;
    assign ctl.kind  = new_kind;
    assign ctl.chr   = i_in_data.char_byte;

    // on every non-subject beat (a restart) the start position is seeded, the chain adds the closure
    assign hop[0]   = !is_step;
    assign carry[0] = 1'b0;

    for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_cell
        slwm_cell #(
            .IDX   (g),
            .LEN_W (LEN_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (ctl),
            .i_len      (r_len),
            .i_len_next (n_len),
            .i_hop      (hop[g]),
            .i_carry    (carry[g]),
            .o_hop      (hop[g+1]),
            .o_carry    (carry[g+1]),
            .o_active   (w_act[g])
        );
    end

    assign w_act[PATTERN_MAX] = r_last;
    assign n_last = in_acc ? (hop[PATTERN_MAX] || carry[PATTERN_MAX]) : r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_esc       <= 1'b0;
            r_ovf       <= 1'b0;
            r_last      <= (PATTERN_MAX == 0);
            r_out_valid <= 1'b0;
        end else begin
            r_len  <= n_len;
            r_esc  <= n_esc;
            r_ovf  <= n_ovf;
            r_last <= n_last;
            if (in_acc && is_end) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && is_end) begin
            r_out.matched          <= w_act[r_len];
            r_out.pattern_overflow <= r_ovf;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_W'(PATTERN_MAX))
        else $error("pattern length beyond capacity");

    a_clear_arms_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && is_clear) |=> (w_act == (PATTERN_MAX + 1)'(1)))
        else $error("clear did not leave only the start position active");

    a_ovf_from_append: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovf) |-> $past(in_acc && is_append))
        else $error("overflow flag set without a pattern beat");

    a_no_result_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall && in_acc) |-> !is_end)
        else $error("end beat taken while a result is held");

endmodule
`default_nettype wire
